/* hdl/hue_brightness_to_led_pwm_defines.svh */
// Assertion macros for the hue to LED compare block.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef HUE_BRIGHTNESS_TO_LED_PWM_DEFINES_SVH
`define HUE_BRIGHTNESS_TO_LED_PWM_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define HBL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define HBL_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("assertion failed");

`endif

/* hdl/hbl_pkg.sv */
package hbl_pkg;

   localparam int HUE_BITS_DEFAULT = 16;
   localparam int LEVEL_BITS       = 8;
   localparam int HUE_IN_BITS      = 16;
   localparam int BRIGHT_BITS      = LEVEL_BITS + 1;

   localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX   = '1;
   localparam logic [BRIGHT_BITS-1:0] BRIGHT_FULL = BRIGHT_BITS'(1 << LEVEL_BITS);

   // Reciprocal constants for the color-correction divides.
   // floor(x/6) == (x*683) >> 12 for x < 2048.
   // floor(x/11) == (x*2979) >> 15 for x < 32768.
   localparam logic [9:0]  RECIP_6      = 10'd683;
   localparam int          RECIP_6_SH   = 12;
   localparam logic [11:0] RECIP_11     = 12'd2979;
   localparam int          RECIP_11_SH  = 15;

   // Hue sectors in order around the color wheel.
   typedef enum logic [2:0] {
      SECTOR_RED_GREEN_UP  = 3'd0,
      SECTOR_RED_DOWN      = 3'd1,
      SECTOR_BLUE_UP       = 3'd2,
      SECTOR_GREEN_DOWN    = 3'd3,
      SECTOR_RED_UP        = 3'd4,
      SECTOR_BLUE_DOWN     = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_IN_BITS-1:0] hue_fraction;
      logic [BRIGHT_BITS-1:0] brightness_level;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] red_compare;
      logic [LEVEL_BITS-1:0] green_compare;
      logic [LEVEL_BITS-1:0] blue_compare;
   } rsp_type;

endpackage

/* hdl/hue_brightness_to_led_pwm.sv */
// Channel       Ports                          Direction  Handshake
// request       start, busy, req_data          in         start && !busy
// response      rsp_valid, rsp_data            out        rsp_valid strobe, one cycle
//
// The response strobe rises once the accepted request has passed the five processing
// stages and the output register.
// A new request may be accepted in every cycle while busy is low; the six register
// stages (five processing stages and the output register) set the latency.
// Reset is synchronous and clears the valid bits of all stages; busy is high
// during reset and in the cycle after it, and low at all other times.
// The receiver cannot stall, so the pipeline never holds and busy never rises for load.
`include "hue_brightness_to_led_pwm_defines.svh"

module hue_brightness_to_led_pwm
   import hbl_pkg::*;
#(
   parameter int HUE_BITS = HUE_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int H6_BITS = HUE_BITS + 3;

   logic accept;

   logic busy_ff;

   // Stage 1: masked hue and saturated brightness.
   logic                    s1_valid_ff;
   logic [HUE_BITS-1:0]     s1_hue_ff,    s1_hue_in;
   logic [BRIGHT_BITS-1:0]  s1_bright_ff, s1_bright_in;
   logic [HUE_BITS+HUE_IN_BITS-1:0] hue_wide;

   // Stage 2: sector and fraction inside the sector.
   logic                    s2_valid_ff;
   logic [2:0]              s2_sector_ff;
   logic [HUE_BITS-1:0]     s2_frac_ff;
   logic [BRIGHT_BITS-1:0]  s2_bright_ff;
   logic [H6_BITS-1:0]      h6_in;

   // Stage 3: unscaled channel levels.
   logic                    s3_valid_ff;
   logic [LEVEL_BITS-1:0]   s3_r_ff, s3_g_ff, s3_b_ff;
   logic [LEVEL_BITS-1:0]   s3_r_in, s3_g_in, s3_b_in;
   logic [BRIGHT_BITS-1:0]  s3_bright_ff;
   logic [HUE_BITS+LEVEL_BITS-1:0] ramp_prod;
   logic [LEVEL_BITS-1:0]   ramp_up, ramp_dn;

   // Stage 4: channels scaled by brightness.
   logic                    s4_valid_ff;
   logic [LEVEL_BITS-1:0]   s4_r_ff, s4_g_ff, s4_b_ff;
   logic [LEVEL_BITS+BRIGHT_BITS-1:0] scale_r, scale_g, scale_b;

   // Stage 5: color-corrected levels, ready for the complement.
   logic                    s5_valid_ff;
   logic [LEVEL_BITS-1:0]   s5_r_ff, s5_g_ff, s5_b_ff;
   logic [10:0]             corr_g_num;
   logic [11:0]             corr_b_num;
   logic [20:0]             corr_g_prod;
   logic [23:0]             corr_b_prod;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff, rsp_data_in;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // Only the low HUE_BITS bits of the hue are used; narrower parameter values
   // drop the top bits and wider ones zero-extend the field.
   assign hue_wide     = {HUE_BITS'(0), req_data.hue_fraction};
   assign s1_hue_in    = hue_wide[HUE_BITS-1:0];
   // Brightness above full saturates to full.
   assign s1_bright_in = (req_data.brightness_level > BRIGHT_FULL) ? BRIGHT_FULL
                                                                  : req_data.brightness_level;

   // Hue times six: the top three bits are the sector and the rest the fraction.
   assign h6_in = {1'b0, s1_hue_ff, 2'b00} + {2'b00, s1_hue_ff, 1'b0};

   // The ramp is floor(frac * 255 / 2^HUE_BITS).
   assign ramp_prod = {s2_frac_ff, LEVEL_BITS'(0)} - {LEVEL_BITS'(0), s2_frac_ff};
   assign ramp_up   = ramp_prod[HUE_BITS+LEVEL_BITS-1:HUE_BITS];
   assign ramp_dn   = LEVEL_MAX - ramp_up;

   always_comb begin
      case (sector_type'(s2_sector_ff))
         SECTOR_RED_GREEN_UP: begin
            s3_r_in = LEVEL_MAX; s3_g_in = ramp_up;   s3_b_in = '0;
         end
         SECTOR_RED_DOWN: begin
            s3_r_in = ramp_dn;   s3_g_in = LEVEL_MAX; s3_b_in = '0;
         end
         SECTOR_BLUE_UP: begin
            s3_r_in = '0;        s3_g_in = LEVEL_MAX; s3_b_in = ramp_up;
         end
         SECTOR_GREEN_DOWN: begin
            s3_r_in = '0;        s3_g_in = ramp_dn;   s3_b_in = LEVEL_MAX;
         end
         SECTOR_RED_UP: begin
            s3_r_in = ramp_up;   s3_g_in = '0;        s3_b_in = LEVEL_MAX;
         end
         default: begin
            s3_r_in = LEVEL_MAX; s3_g_in = '0;        s3_b_in = ramp_dn;
         end
      endcase
   end

   // Brightness scaling: floor(c * bright / 256). The result never exceeds 255.
   assign scale_r = {{BRIGHT_BITS{1'b0}}, s3_r_ff} * {{LEVEL_BITS{1'b0}}, s3_bright_ff};
   assign scale_g = {{BRIGHT_BITS{1'b0}}, s3_g_ff} * {{LEVEL_BITS{1'b0}}, s3_bright_ff};
   assign scale_b = {{BRIGHT_BITS{1'b0}}, s3_b_ff} * {{LEVEL_BITS{1'b0}}, s3_bright_ff};

   // Green is ceil(5g/6) and blue ceil(10b/11), each as a biased numerator
   // multiplied by a reciprocal and shifted.
   assign corr_g_num  = ({3'b000, s4_g_ff} << 2) + {3'b000, s4_g_ff} + 11'd5;
   assign corr_b_num  = ({4'b0000, s4_b_ff} << 3) + ({4'b0000, s4_b_ff} << 1) + 12'd10;
   assign corr_g_prod = {10'd0, corr_g_num} * {11'd0, RECIP_6};
   assign corr_b_prod = {12'd0, corr_b_num} * {12'd0, RECIP_11};

   // The drive is active low, so each compare value is the complement of the level.
   always_comb begin
      rsp_data_in.red_compare   = LEVEL_MAX - s5_r_ff;
      rsp_data_in.green_compare = LEVEL_MAX - s5_g_ff;
      rsp_data_in.blue_compare  = LEVEL_MAX - s5_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_ff    <= s1_hue_in;
      s1_bright_ff <= s1_bright_in;

      s2_sector_ff <= h6_in[H6_BITS-1:HUE_BITS];
      s2_frac_ff   <= h6_in[HUE_BITS-1:0];
      s2_bright_ff <= s1_bright_ff;

      s3_r_ff      <= s3_r_in;
      s3_g_ff      <= s3_g_in;
      s3_b_ff      <= s3_b_in;
      s3_bright_ff <= s2_bright_ff;

      s4_r_ff      <= scale_r[2*LEVEL_BITS-1:LEVEL_BITS];
      s4_g_ff      <= scale_g[2*LEVEL_BITS-1:LEVEL_BITS];
      s4_b_ff      <= scale_b[2*LEVEL_BITS-1:LEVEL_BITS];

      s5_r_ff      <= s4_r_ff;
      s5_g_ff      <= corr_g_prod[RECIP_6_SH+LEVEL_BITS-1:RECIP_6_SH];
      s5_b_ff      <= corr_b_prod[RECIP_11_SH+LEVEL_BITS-1:RECIP_11_SH];

      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Brightness is saturated as it enters the pipeline.
   `HBL_ASSERT_NEXT(a_bright_saturated, accept, s1_bright_ff <= BRIGHT_FULL)

   // Every sector leaves at least one channel off.
   `HBL_ASSERT_NEXT(a_one_channel_off, s2_valid_ff,
      s3_r_ff == '0 || s3_g_ff == '0 || s3_b_ff == '0)

   // Every accepted request gives a response strobe.
   `HBL_ASSERT_DELAY(a_latency, accept, 6, rsp_valid)

   // Zero brightness turns the LED fully off on every channel.
   `HBL_ASSERT_DELAY(a_dark_is_off, accept && req_data.brightness_level == '0, 6,
      rsp_data.red_compare == LEVEL_MAX && rsp_data.green_compare == LEVEL_MAX &&
      rsp_data.blue_compare == LEVEL_MAX)

endmodule
